### rtl/core/qha_pkg.sv
// qha_pkg: widths, constants, register indexes and types of the heading alignment block
// used by qha_angles and quaternion_heading_alignment_top; no dependencies
`timescale 1ns / 1ps
package qha_pkg;

	localparam int CW          = 16;
	localparam int PW          = 35;
	localparam int HW          = 34;
	localparam int N2W         = 33;
	localparam int Q_W         = 31;
	localparam int S_W         = 32;
	localparam int DIV_STEPS   = 31;
	localparam int SQ_W        = 62;
	localparam int V_W         = 61;
	localparam int SQRT_STEPS  = 31;
	localparam int SQRT_TOP    = 60;
	localparam int XW          = 46;
	localparam int ZW          = 24;
	localparam int AW          = 17;
	localparam int NORM_EXP    = 40;
	localparam int NORM_STAGES = 7;
	localparam int ANGLE_LAG   = DIV_STEPS + 2 + SQRT_STEPS;
	localparam int CFG_W       = 16;
	localparam int THR_W       = 15;
	localparam int IDX_W       = 3;

	localparam logic signed [ZW-1:0] DEG90       = 24'sd2949120;
	localparam logic signed [AW-1:0] YAW_LIMIT   = 17'sd23040;
	localparam logic signed [AW-1:0] PITCH_LIMIT = 17'sd11520;

	localparam logic [IDX_W-1:0] REG_PRESET_W  = 3'd0;
	localparam logic [IDX_W-1:0] REG_PRESET_X  = 3'd1;
	localparam logic [IDX_W-1:0] REG_PRESET_Y  = 3'd2;
	localparam logic [IDX_W-1:0] REG_PRESET_Z  = 3'd3;
	localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd4;
	localparam logic [IDX_W-1:0] REG_TURN_RATE = 3'd5;

	localparam logic [CFG_W-1:0] RST_PRESET_W  = 16'd7558;
	localparam logic [CFG_W-1:0] RST_PRESET_X  = 16'hFEA5;
	localparam logic [CFG_W-1:0] RST_PRESET_Y  = 16'd357;
	localparam logic [CFG_W-1:0] RST_PRESET_Z  = 16'd14528;
	localparam logic [THR_W-1:0] RST_THRESHOLD = 15'd640;
	localparam logic [THR_W-1:0] RST_TURN_RATE = 15'd8192;

	typedef struct packed {
		logic signed [AW-1:0] yaw;
		logic signed [AW-1:0] pitch;
	} angles_t;

	// atan(2^-i) in 2^-15 degree
	function automatic logic [21:0] atan_step(input int i);
		logic [21:0] v;
		case (i)
			0:  v = 22'd1474560;
			1:  v = 22'd870484;
			2:  v = 22'd459940;
			3:  v = 22'd233473;
			4:  v = 22'd117189;
			5:  v = 22'd58652;
			6:  v = 22'd29333;
			7:  v = 22'd14667;
			8:  v = 22'd7334;
			9:  v = 22'd3667;
			10: v = 22'd1833;
			11: v = 22'd917;
			12: v = 22'd458;
			13: v = 22'd229;
			14: v = 22'd115;
			15: v = 22'd57;
			16: v = 22'd29;
			17: v = 22'd14;
			18: v = 22'd7;
			19: v = 22'd4;
			20: v = 22'd2;
			21: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

### rtl/core/qha_angles.sv
// qha_angles: pipelined yaw and pitch of one quaternion (products, divider, square root, cordic)
// depends on qha_pkg
`timescale 1ns / 1ps
module qha_angles #(
	parameter int QUAT_WIDTH   = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [QUAT_WIDTH-1:0]   qw,
	input  logic [QUAT_WIDTH-1:0]   qx,
	input  logic [QUAT_WIDTH-1:0]   qy,
	input  logic [QUAT_WIDTH-1:0]   qz,
	output logic                    out_valid,
	output qha_pkg::angles_t        angles
);
	import qha_pkg::*;

	localparam int PRE_SHIFT = (QUAT_WIDTH > CW) ? QUAT_WIDTH - CW : 0;
	localparam int LANE_LAT  = 2 + NORM_STAGES + CORDIC_STEPS;
	localparam int LAT       = 3 + ANGLE_LAG + LANE_LAT;

	function automatic logic signed [CW-1:0] comp(input logic [QUAT_WIDTH-1:0] v);
		logic signed [QUAT_WIDTH-1:0] sv;
		sv = v;
		return CW'(sv >>> PRE_SHIFT);
	endfunction

	function automatic logic [XW-1:0] mag(input logic signed [XW-1:0] v);
		return (v < 0) ? XW'(-v) : XW'(v);
	endfunction

	logic vld_q [LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
		end else begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	assign out_valid = vld_q[LAT-1];

	// components and products
	logic signed [CW-1:0] w_s1, x_s1, y_s1, z_s1;
	logic signed [31:0] ww_s2, xx_s2, yy_s2, zz_s2, wz_s2, xy_s2, wy_s2, zx_s2;
	logic [N2W-1:0]       n2_s3;
	logic [N2W-1:0]       amag_s3;
	logic                 aneg_s3;
	logic signed [HW-1:0] hx_s3, hy_s3;
	logic signed [PW-1:0] sum_sq, hx_c, hy_c, a_c;

	always_ff @(posedge clk) begin
		w_s1  <= comp(qw);
		x_s1  <= comp(qx);
		y_s1  <= comp(qy);
		z_s1  <= comp(qz);
		ww_s2 <= w_s1 * w_s1;
		xx_s2 <= x_s1 * x_s1;
		yy_s2 <= y_s1 * y_s1;
		zz_s2 <= z_s1 * z_s1;
		wz_s2 <= w_s1 * z_s1;
		xy_s2 <= x_s1 * y_s1;
		wy_s2 <= w_s1 * y_s1;
		zx_s2 <= z_s1 * x_s1;
	end

	always_comb begin
		sum_sq = PW'(ww_s2) + PW'(xx_s2) + PW'(yy_s2) + PW'(zz_s2);
		hx_c   = PW'(ww_s2) + PW'(xx_s2) - PW'(yy_s2) - PW'(zz_s2);
		hy_c   = (PW'(wz_s2) + PW'(xy_s2)) <<< 1;
		a_c    = (PW'(wy_s2) - PW'(zx_s2)) <<< 1;
	end

	always_ff @(posedge clk) begin
		n2_s3   <= N2W'(sum_sq);
		hx_s3   <= HW'(hx_c);
		hy_s3   <= HW'(hy_c);
		aneg_s3 <= a_c < 0;
		amag_s3 <= (a_c < 0) ? N2W'(-a_c) : N2W'(a_c);
	end

	// restoring divider, one quotient bit a stage; |a| never exceeds n2
	logic [N2W-1:0] dv_rem_s4 [DIV_STEPS];
	logic [N2W-1:0] dv_n2_s4  [DIV_STEPS];
	logic [Q_W-1:0] dv_quo_s4 [DIV_STEPS];
	logic           dv_neg_s4 [DIV_STEPS];
	logic           dv_nz_s4  [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [N2W:0]   num;
		logic [N2W-1:0] den;
		logic           qbit;
		if (k == 0) begin : g_first
			assign num = {1'b0, amag_s3};
			assign den = n2_s3;
			always_ff @(posedge clk) begin
				dv_quo_s4[k] <= Q_W'(qbit);
				dv_neg_s4[k] <= aneg_s3;
				dv_nz_s4[k]  <= n2_s3 != '0;
			end
		end else begin : g_next
			assign num = {dv_rem_s4[k-1], 1'b0};
			assign den = dv_n2_s4[k-1];
			always_ff @(posedge clk) begin
				dv_quo_s4[k] <= {dv_quo_s4[k-1][Q_W-2:0], qbit};
				dv_neg_s4[k] <= dv_neg_s4[k-1];
				dv_nz_s4[k]  <= dv_nz_s4[k-1];
			end
		end
		assign qbit = num >= {1'b0, den};
		always_ff @(posedge clk) begin
			dv_n2_s4[k]  <= den;
			dv_rem_s4[k] <= qbit ? N2W'(num - {1'b0, den}) : N2W'(num);
		end
	end

	// sine and its square
	logic [Q_W-1:0]       qmag;
	logic signed [S_W-1:0] s_s5, s_s6;
	logic [SQ_W-1:0]      sq_s5;
	logic [V_W-1:0]       v_s6;

	assign qmag = dv_nz_s4[DIV_STEPS-1] ? dv_quo_s4[DIV_STEPS-1] : '0;

	always_ff @(posedge clk) begin
		s_s5  <= dv_neg_s4[DIV_STEPS-1] ? -S_W'(qmag) : S_W'(qmag);
		sq_s5 <= SQ_W'(qmag) * SQ_W'(qmag);
		s_s6  <= s_s5;
		v_s6  <= V_W'((SQ_W'(1) << SQRT_TOP) - sq_s5);
	end

	// digit-by-digit square root, one result bit a stage
	logic [V_W-1:0]        sr_v_s7 [SQRT_STEPS];
	logic [SQ_W-1:0]       sr_r_s7 [SQRT_STEPS];
	logic signed [S_W-1:0] sr_s_s7 [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [SQ_W-1:0] ONE_BIT = SQ_W'(1) << (SQRT_TOP - 2 * k);
		logic [V_W-1:0]  v_in;
		logic [SQ_W-1:0] r_in, t;
		if (k == 0) begin : g_first
			assign v_in = v_s6;
			assign r_in = '0;
			always_ff @(posedge clk) sr_s_s7[k] <= s_s6;
		end else begin : g_next
			assign v_in = sr_v_s7[k-1];
			assign r_in = sr_r_s7[k-1];
			always_ff @(posedge clk) sr_s_s7[k] <= sr_s_s7[k-1];
		end
		assign t = r_in + ONE_BIT;
		always_ff @(posedge clk) begin
			if ({1'b0, v_in} >= t) begin
				sr_v_s7[k] <= V_W'({1'b0, v_in} - t);
				sr_r_s7[k] <= (r_in >> 1) + ONE_BIT;
			end else begin
				sr_v_s7[k] <= v_in;
				sr_r_s7[k] <= r_in >> 1;
			end
		end
	end

	// cordic vectoring lanes: yaw from (hx, hy), pitch from (c, s)
	logic signed [AW-1:0] lane_ang [2];

	for (genvar g = 0; g < 2; g++) begin : g_lane
		localparam logic signed [AW-1:0] LIM = (g == 0) ? YAW_LIMIT : PITCH_LIMIT;
		logic signed [XW-1:0] lx, ly;
		logic signed [XW-1:0] p_x_s8, p_y_s8;
		logic signed [ZW-1:0] p_z_s8;
		logic                 p_zero_s8;
		logic signed [XW-1:0] n_x_s9 [NORM_STAGES];
		logic signed [XW-1:0] n_y_s9 [NORM_STAGES];
		logic signed [ZW-1:0] n_z_s9 [NORM_STAGES];
		logic                 n_zero_s9 [NORM_STAGES];
		logic signed [XW-1:0] c_x_s10 [CORDIC_STEPS];
		logic signed [XW-1:0] c_y_s10 [CORDIC_STEPS];
		logic signed [ZW-1:0] c_z_s10 [CORDIC_STEPS];
		logic                 c_zero_s10 [CORDIC_STEPS];
		logic signed [ZW-1:0] zr, zs;

		if (g == 0) begin : g_yaw_in
			assign lx = XW'(hx_s3);
			assign ly = XW'(hy_s3);
		end else begin : g_pitch_in
			assign lx = XW'(sr_r_s7[SQRT_STEPS-1]);
			assign ly = XW'(sr_s_s7[SQRT_STEPS-1]);
		end

		always_ff @(posedge clk) begin
			p_zero_s8 <= (lx == '0) && (ly == '0);
			if (lx < 0) begin
				if (ly >= 0) begin
					p_x_s8 <= ly;
					p_y_s8 <= -lx;
					p_z_s8 <= DEG90;
				end else begin
					p_x_s8 <= -ly;
					p_y_s8 <= lx;
					p_z_s8 <= -DEG90;
				end
			end else begin
				p_x_s8 <= lx;
				p_y_s8 <= ly;
				p_z_s8 <= '0;
			end
		end

		// binary search of the doubling count, then one last doubling
		for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
			localparam int SH = (j < NORM_STAGES - 1) ? (32 >> j) : 1;
			localparam int EXP = (j < NORM_STAGES - 1) ? NORM_EXP - SH : NORM_EXP;
			localparam logic [XW-1:0] LIMV = XW'(1) << EXP;
			logic signed [XW-1:0] xi, yi;
			logic signed [ZW-1:0] zi;
			logic                 zero_i;
			if (j == 0) begin : g_first
				assign xi = p_x_s8;
				assign yi = p_y_s8;
				assign zi = p_z_s8;
				assign zero_i = p_zero_s8;
			end else begin : g_next
				assign xi = n_x_s9[j-1];
				assign yi = n_y_s9[j-1];
				assign zi = n_z_s9[j-1];
				assign zero_i = n_zero_s9[j-1];
			end
			always_ff @(posedge clk) begin
				if ((mag(xi) < LIMV) && (mag(yi) < LIMV)) begin
					n_x_s9[j] <= xi <<< SH;
					n_y_s9[j] <= yi <<< SH;
				end else begin
					n_x_s9[j] <= xi;
					n_y_s9[j] <= yi;
				end
				n_z_s9[j]    <= zi;
				n_zero_s9[j] <= zero_i;
			end
		end

		for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
			localparam logic signed [ZW-1:0] ANG = ZW'(atan_step(i));
			logic signed [XW-1:0] xi, yi;
			logic signed [ZW-1:0] zi;
			logic                 zero_i;
			if (i == 0) begin : g_first
				assign xi = n_x_s9[NORM_STAGES-1];
				assign yi = n_y_s9[NORM_STAGES-1];
				assign zi = n_z_s9[NORM_STAGES-1];
				assign zero_i = n_zero_s9[NORM_STAGES-1];
			end else begin : g_next
				assign xi = c_x_s10[i-1];
				assign yi = c_y_s10[i-1];
				assign zi = c_z_s10[i-1];
				assign zero_i = c_zero_s10[i-1];
			end
			always_ff @(posedge clk) begin
				if (yi >= 0) begin
					c_x_s10[i] <= xi + (yi >>> i);
					c_y_s10[i] <= yi - (xi >>> i);
					c_z_s10[i] <= zi + ANG;
				end else begin
					c_x_s10[i] <= xi - (yi >>> i);
					c_y_s10[i] <= yi + (xi >>> i);
					c_z_s10[i] <= zi - ANG;
				end
				c_zero_s10[i] <= zero_i;
			end
		end

		assign zr = c_z_s10[CORDIC_STEPS-1] + ZW'(128);
		assign zs = zr >>> 8;

		always_ff @(posedge clk) begin
			if (c_zero_s10[CORDIC_STEPS-1])
				lane_ang[g] <= '0;
			else if (zs > ZW'(LIM))
				lane_ang[g] <= LIM;
			else if (zs < -ZW'(LIM))
				lane_ang[g] <= -LIM;
			else
				lane_ang[g] <= AW'(zs);
		end
	end

	// yaw waits for the divider and square root of the pitch path
	logic signed [AW-1:0] yaw_s12 [ANGLE_LAG];

	always_ff @(posedge clk) begin
		yaw_s12[0] <= lane_ang[0];
		for (int k = 1; k < ANGLE_LAG; k++) yaw_s12[k] <= yaw_s12[k-1];
	end

	assign angles.yaw   = yaw_s12[ANGLE_LAG-1];
	assign angles.pitch = lane_ang[1];

endmodule

### rtl/core/quaternion_heading_alignment_top.sv
// quaternion_heading_alignment_top: heading and pitch errors against a preset quaternion
// depends on qha_pkg and qha_angles
//
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------------
// request   | start, busy          | quat_w, quat_x, quat_y, quat_z
// result    | done (one cycle)     | aligned, omega_command, yaw_error, pitch_error
// config    | wr_en                | wr_index, wr_data
//
// one request per cycle; busy stays low
// a result follows its request through the 31-step divider, the 31-step square root
// and the cordic stages
// reset clears the valid bits and loads the preset, threshold and turn rate registers; nothing stalls
`timescale 1ns / 1ps
module quaternion_heading_alignment_top #(
	parameter int QUAT_WIDTH   = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [QUAT_WIDTH-1:0]             quat_w,
	input  logic [QUAT_WIDTH-1:0]             quat_x,
	input  logic [QUAT_WIDTH-1:0]             quat_y,
	input  logic [QUAT_WIDTH-1:0]             quat_z,
	input  logic                              wr_en,
	input  logic [qha_pkg::IDX_W-1:0]         wr_index,
	input  logic [qha_pkg::CFG_W-1:0]         wr_data,
	output logic                              done,
	output logic                              aligned,
	output logic signed [15:0]                omega_command,
	output logic signed [16:0]                yaw_error,
	output logic signed [15:0]                pitch_error
);
	import qha_pkg::*;

	logic [CFG_W-1:0] preset_w_q, preset_x_q, preset_y_q, preset_z_q;
	logic [THR_W-1:0] threshold_q, turn_rate_q;
	logic             accept;
	logic             cur_vld, pre_vld, res_vld;
	angles_t          cur_ang, pre_ang;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_w_q  <= RST_PRESET_W;
			preset_x_q  <= RST_PRESET_X;
			preset_y_q  <= RST_PRESET_Y;
			preset_z_q  <= RST_PRESET_Z;
			threshold_q <= RST_THRESHOLD;
			turn_rate_q <= RST_TURN_RATE;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PRESET_W:  preset_w_q  <= wr_data;
				REG_PRESET_X:  preset_x_q  <= wr_data;
				REG_PRESET_Y:  preset_y_q  <= wr_data;
				REG_PRESET_Z:  preset_z_q  <= wr_data;
				REG_THRESHOLD: threshold_q <= THR_W'(wr_data);
				REG_TURN_RATE: turn_rate_q <= THR_W'(wr_data);
				default: ;
			endcase
		end
	end

	qha_angles #(
		.QUAT_WIDTH   (QUAT_WIDTH),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cur (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.qw        (quat_w),
		.qx        (quat_x),
		.qy        (quat_y),
		.qz        (quat_z),
		.out_valid (cur_vld),
		.angles    (cur_ang)
	);

	// preset runs alongside every request
	qha_angles #(
		.QUAT_WIDTH   (QUAT_WIDTH),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.qw        (QUAT_WIDTH'(preset_w_q)),
		.qx        (QUAT_WIDTH'(preset_x_q)),
		.qy        (QUAT_WIDTH'(preset_y_q)),
		.qz        (QUAT_WIDTH'(preset_z_q)),
		.out_valid (pre_vld),
		.angles    (pre_ang)
	);

	assign res_vld = cur_vld & pre_vld;

	logic                 vld_s1, vld_s2;
	logic signed [17:0]   yerr_s1, perr_s1;
	logic [17:0]          yabs, pabs;
	logic                 ok;
	logic                 aligned_s2;
	logic signed [15:0]   omega_s2;
	logic signed [16:0]   yerr_s2;
	logic signed [15:0]   perr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= res_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		yerr_s1 <= 18'(pre_ang.yaw) - 18'(cur_ang.yaw);
		perr_s1 <= 18'(pre_ang.pitch) - 18'(cur_ang.pitch);
	end

	always_comb begin
		yabs = (yerr_s1 < 0) ? 18'(-yerr_s1) : 18'(yerr_s1);
		pabs = (perr_s1 < 0) ? 18'(-perr_s1) : 18'(perr_s1);
		ok   = (yabs < 18'(threshold_q)) && (pabs < 18'(threshold_q));
	end

	always_ff @(posedge clk) begin
		aligned_s2 <= ok;
		yerr_s2    <= 17'(yerr_s1);
		perr_s2    <= 16'(perr_s1);
		if (ok)
			omega_s2 <= '0;
		else if (yerr_s1 > 0)
			omega_s2 <= $signed({1'b0, turn_rate_q});
		else
			omega_s2 <= -$signed({1'b0, turn_rate_q});
	end

	assign done          = vld_s2;
	assign aligned       = aligned_s2;
	assign omega_command = omega_s2;
	assign yaw_error     = yerr_s2;
	assign pitch_error   = perr_s2;

endmodule

### rtl/core/qha_checker.sv
// qha_checker: port-level checks on results of the heading alignment block
// bound to quaternion_heading_alignment_top; no package needed
`timescale 1ns / 1ps
module qha_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               done,
	input logic               aligned,
	input logic signed [15:0] omega_command,
	input logic signed [16:0] yaw_error,
	input logic signed [15:0] pitch_error
);

	a_aligned_no_turn: assert property (@(posedge clk) disable iff (!arst_n)
		done && aligned |-> omega_command == 16'sd0)
		else $error("aligned result with nonzero turn command");

	a_turn_positive: assert property (@(posedge clk) disable iff (!arst_n)
		done && !aligned && (yaw_error > 17'sd0) |-> !omega_command[15])
		else $error("positive yaw error with negative turn command");

	a_turn_negative: assert property (@(posedge clk) disable iff (!arst_n)
		done && !aligned && (yaw_error <= 17'sd0) |-> omega_command[15] || omega_command == 16'sd0)
		else $error("non-positive yaw error with positive turn command");

	a_error_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (yaw_error >= -17'sd46080) && (yaw_error <= 17'sd46080)
			&& (pitch_error >= -16'sd23040) && (pitch_error <= 16'sd23040))
		else $error("angle error out of range");

endmodule

bind quaternion_heading_alignment_top qha_checker u_qha_checker (.*);

### sim/testbench.sv
// testbench: self-checking bench for quaternion_heading_alignment_top
// predicts angle errors, aligned flag and turn command per request; depends on qha_pkg
`timescale 1ns / 1ps
module testbench;
	import qha_pkg::*;

	localparam int N_RANDOM  = 1850;
	localparam int LATENCY   = 94;
	localparam int WD_LIMIT  = 20000;
	localparam int N_DIRECT  = 14;

	typedef struct {
		logic [15:0] w, x, y, z;
		bit          chk;
		logic        aligned;
		logic [15:0] omega;
		logic [16:0] yaw;
		logic [15:0] pitch;
	} stim_row_t;

	typedef struct {
		logic        aligned;
		logic [15:0] omega;
		logic [16:0] yaw;
		logic [15:0] pitch;
	} heading_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [15:0] quat_w = 0, quat_x = 0, quat_y = 0, quat_z = 0;
	logic wr_en = 0;
	logic [IDX_W-1:0] wr_index = '0;
	logic [CFG_W-1:0] wr_data = '0;
	logic busy, done, aligned;
	logic signed [15:0] omega_command;
	logic signed [16:0] yaw_error;
	logic signed [15:0] pitch_error;

	logic [15:0] tgt_w, tgt_x, tgt_y, tgt_z;
	logic [14:0] thr_reg, rate_reg;

	bit              typed_on = 1'b0;
	heading_result_t typed_res;

	heading_result_t pending_results[$];
	int errors = 0;
	int n_requests = 0;
	int n_results = 0;
	int idle_cycles = 0;
	int n_aligned = 0;

	quaternion_heading_alignment_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.done(done), .aligned(aligned), .omega_command(omega_command),
		.yaw_error(yaw_error), .pitch_error(pitch_error)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint root_floor(longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 << 62;
		while (b > v) b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint vector_angle(longint vx, longint vy);
		longint ang, t, dx, dy;
		ang = 0;
		if (vx == 0 && vy == 0) return 0;
		if (vx < 0) begin
			t = vx;
			if (vy >= 0) begin
				vx = vy; vy = -t; ang = longint'(DEG90);
			end else begin
				vx = -vy; vy = t; ang = -longint'(DEG90);
			end
		end
		while (abs64(vx) < (64'sd1 << NORM_EXP) && abs64(vy) < (64'sd1 << NORM_EXP)) begin
			vx = vx * 2;
			vy = vy * 2;
		end
		for (int i = 0; i < 16; i++) begin
			dx = floor_shift(vy, i);
			dy = floor_shift(vx, i);
			if (vy >= 0) begin
				vx += dx; vy -= dy; ang += longint'(atan_step(i));
			end else begin
				vx -= dx; vy += dy; ang -= longint'(atan_step(i));
			end
		end
		return floor_shift(ang + 128, 8);
	endfunction

	function automatic longint clip(longint v, longint lim);
		return v < -lim ? -lim : (v > lim ? lim : v);
	endfunction

	function automatic void quat_angles(input logic [15:0] qw, qx, qy, qz,
			output longint head, output longint tilt);
		longint w, x, y, z, n2, hx, hy, a, s, c, unit;
		w = longint'($signed(qw));
		x = longint'($signed(qx));
		y = longint'($signed(qy));
		z = longint'($signed(qz));
		unit = 64'sd1 << 30;
		n2 = w*w + x*x + y*y + z*z;
		hx = n2 - 2*(y*y + z*z);
		hy = 2*(w*z + x*y);
		a = 2*(w*y - z*x);
		s = 0;
		if (n2 > 0) s = clip((a * unit) / n2, unit);
		c = root_floor((64'sd1 << 60) - s*s);
		head = clip(vector_angle(hx, hy), 23040);
		tilt = clip(vector_angle(c, s), 11520);
	endfunction

	function automatic heading_result_t predict_heading(logic [15:0] qw, qx, qy, qz);
		heading_result_t r;
		longint ph, pt, ch, ct, ye, pe, thr, om;
		quat_angles(tgt_w, tgt_x, tgt_y, tgt_z, ph, pt);
		quat_angles(qw, qx, qy, qz, ch, ct);
		ye = ph - ch;
		pe = pt - ct;
		thr = longint'(thr_reg);
		r.aligned = abs64(ye) < thr && abs64(pe) < thr;
		if (r.aligned) om = 0;
		else if (ye > 0) om = longint'(rate_reg);
		else om = -longint'(rate_reg);
		r.omega = om[15:0];
		r.yaw = ye[16:0];
		r.pitch = pe[15:0];
		return r;
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 0;
		case (idx)
			REG_PRESET_W:  tgt_w = val;
			REG_PRESET_X:  tgt_x = val;
			REG_PRESET_Y:  tgt_y = val;
			REG_PRESET_Z:  tgt_z = val;
			REG_THRESHOLD: thr_reg = val[14:0];
			REG_TURN_RATE: rate_reg = val[14:0];
			default: ;
		endcase
	endtask

	// wait for the pipeline to drain before touching registers
	task automatic drain();
		@(negedge clk);
		start <= 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// leaves start high; caller lowers it
	task automatic send_quat(input logic [15:0] qw, qx, qy, qz);
		@(negedge clk);
		start <= 1;
		quat_w <= qw; quat_x <= qx; quat_y <= qy; quat_z <= qz;
		typed_on <= 1'b0;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// table row; a typed result replaces the prediction for this request
	task automatic send_row(input stim_row_t row);
		@(negedge clk);
		start <= 1;
		quat_w <= row.w; quat_x <= row.x; quat_y <= row.y; quat_z <= row.z;
		typed_on <= row.chk;
		typed_res <= '{row.aligned, row.omega, row.yaw, row.pitch};
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			if (typed_on)
				pending_results.push_back(typed_res);
			else
				pending_results.push_back(predict_heading(quat_w, quat_x, quat_y, quat_z));
			n_requests++;
		end
		if (arst_n && done) begin
			heading_result_t e;
			n_results++;
			if (pending_results.size() == 0) begin
				$error("result with no request pending");
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (aligned !== e.aligned) begin
					$error("aligned exp %0d got %0d", e.aligned, aligned);
					errors++;
				end
				if (omega_command !== e.omega) begin
					$error("omega_command exp %0d got %0d", $signed(e.omega), omega_command);
					errors++;
				end
				if (yaw_error !== e.yaw) begin
					$error("yaw_error exp %0d got %0d", $signed(e.yaw), yaw_error);
					errors++;
				end
				if (pitch_error !== e.pitch) begin
					$error("pitch_error exp %0d got %0d", $signed(e.pitch), pitch_error);
					errors++;
				end
				if (e.aligned) n_aligned++;
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || wr_en || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WD_LIMIT) begin
			$display("[quaternion_heading_alignment_top] ERROR");
			$finish;
		end
	end

	function automatic logic [15:0] rand_comp(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 32767) - 16384);
			2: return 16'($urandom_range(0, 1023) - 512);
			default: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
		endcase
	endfunction

	stim_row_t directed_rows[N_DIRECT];

	initial begin
		int mode, burst;
		logic [15:0] a, b, c, d;
		tgt_w = RST_PRESET_W; tgt_x = RST_PRESET_X;
		tgt_y = RST_PRESET_Y; tgt_z = RST_PRESET_Z;
		thr_reg = RST_THRESHOLD; rate_reg = RST_TURN_RATE;

		// w x y z, then typed result where obvious
		directed_rows[0]  = '{RST_PRESET_W, RST_PRESET_X, RST_PRESET_Y, RST_PRESET_Z,
			1, 1'b1, 16'd0, 17'd0, 16'd0};
		directed_rows[1]  = '{16'd0, 16'd0, 16'd0, 16'd0, 0, 0, 0, 0, 0};
		directed_rows[2]  = '{16'h4000, 16'd0, 16'd0, 16'd0, 0, 0, 0, 0, 0};
		directed_rows[3]  = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0, 0};
		directed_rows[4]  = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0, 0};
		directed_rows[5]  = '{16'd0, 16'd0, 16'd0, 16'h4000, 0, 0, 0, 0, 0};
		directed_rows[6]  = '{16'd0, 16'h4000, 16'd0, 16'd0, 0, 0, 0, 0, 0};
		directed_rows[7]  = '{16'h2D41, 16'd0, 16'h2D41, 16'd0, 0, 0, 0, 0, 0};
		directed_rows[8]  = '{16'h2D41, 16'd0, 16'hD2BF, 16'd0, 0, 0, 0, 0, 0};
		directed_rows[9]  = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0, 0, 0, 0, 0};
		directed_rows[10] = '{16'h0001, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 0, 0};
		directed_rows[11] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0};
		directed_rows[12] = '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 0, 0, 0, 0, 0};
		directed_rows[13] = '{16'h0000, 16'h0000, 16'h4000, 16'h0000, 0, 0, 0, 0, 0};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		for (int i = 0; i < N_DIRECT; i++) send_row(directed_rows[i]);
		drain();

		// extreme register settings, plus two unused indexes
		write_reg(REG_THRESHOLD, 16'd0);
		write_reg(REG_TURN_RATE, 16'h7FFF);
		write_reg(3'd6, 16'h1234);
		write_reg(3'd7, 16'hFFFF);
		for (int i = 0; i < 6; i++) send_quat(rand_comp(0), rand_comp(1), rand_comp(2), rand_comp(0));
		send_quat(RST_PRESET_W, RST_PRESET_X, RST_PRESET_Y, RST_PRESET_Z);
		drain();
		write_reg(REG_THRESHOLD, 16'hFFFF);
		write_reg(REG_TURN_RATE, 16'd0);
		for (int i = 0; i < 4; i++) send_quat(rand_comp(0), rand_comp(1), rand_comp(0), rand_comp(3));
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_PRESET_W, 16'h7FFF); write_reg(REG_PRESET_X, 16'h8000);
					write_reg(REG_PRESET_Y, 16'h0000); write_reg(REG_PRESET_Z, 16'hFFFF);
				end
				1: begin
					write_reg(REG_PRESET_W, 16'd0); write_reg(REG_PRESET_X, 16'd0);
					write_reg(REG_PRESET_Y, 16'd0); write_reg(REG_PRESET_Z, 16'd0);
				end
				default: begin
					write_reg(REG_PRESET_W, rand_comp(phase % 3));
					write_reg(REG_PRESET_X, rand_comp(1));
					write_reg(REG_PRESET_Y, rand_comp(0));
					write_reg(REG_PRESET_Z, rand_comp(phase % 2 + 1));
				end
			endcase
			write_reg(REG_THRESHOLD, 16'($urandom_range(0, 23040)));
			write_reg(REG_TURN_RATE, 16'($urandom));
			for (int n = 0; n < N_RANDOM / 6; ) begin
				burst = $urandom_range(1, 40);
				for (int k = 0; k < burst && n < N_RANDOM / 6; k++, n++) begin
					mode = $urandom_range(0, 9);
					if (mode < 2) begin
						// near the preset so alignment is seen
						a = tgt_w + 16'($urandom_range(0, 200) - 100);
						b = tgt_x + 16'($urandom_range(0, 200) - 100);
						c = tgt_y + 16'($urandom_range(0, 200) - 100);
						d = tgt_z + 16'($urandom_range(0, 200) - 100);
					end else begin
						a = rand_comp(mode % 4); b = rand_comp((mode + 1) % 4);
						c = rand_comp(mode % 3); d = rand_comp((mode + 2) % 4);
					end
					send_quat(a, b, c, d);
				end
				@(negedge clk);
				start <= 0;
				if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 30)) @(negedge clk);
			end
			drain();
		end

		repeat (LATENCY + 10) @(negedge clk);
		$display("%0d requests, %0d results (%0d aligned) over six preset settings",
			n_requests, n_results, n_aligned);
		if (errors == 0 && pending_results.size() == 0)
			$display("[quaternion_heading_alignment_top] OK");
		else
			$display("[quaternion_heading_alignment_top] ERROR");
		$finish;
	end
endmodule
